// ===== src/voxel_aggregation_walker_step_unit_defines.svh =====
// assertion macros for the voxel aggregation walker step unit
// no dependencies; the macros expect clk and rst_n in the enclosing module
`ifndef VOXEL_AGGREGATION_WALKER_STEP_UNIT_DEFINES_SVH
`define VOXEL_AGGREGATION_WALKER_STEP_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define VAW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define VAW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vaw_pkg.sv =====
// shared types and codes for the voxel aggregation walker step unit
// no dependencies
package vaw_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int KIND_W      = 3;
  localparam int CMD_W       = 1;

  // internal coordinate width, holds a stepped position and its neighbours
  localparam int CW    = 7;
  // output and queued coordinate width
  localparam int OCW   = 6;
  localparam int PT_W  = 3 * OCW;

  // commands
  localparam logic [CMD_W-1:0] CMD_MOVE   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MOVED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STUCK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OUT     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PRESENT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd5;

  // respawn face axes, anything else means z
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MV_SCAN,
    ST_MV_LAST,
    ST_MV_EMIT,
    ST_CM_PREAD,
    ST_CM_GREAD,
    ST_CM_EMIT,
    ST_CM_EMPTY
  } vaw_state_t;

endpackage

// ===== src/vaw_ram.sv =====
// single-port ram with registered read data, no reset on contents
// depends on nothing
module vaw_ram #(
  parameter int DW    = 1,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // read data holds while the port is idle or writing
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== src/vaw_addr_unit.sv =====
// grid row address unit: maps an (x, y) pair to a z-row of the grid
// depends on vaw_pkg
module vaw_addr_unit #(
  parameter int BOUND = 15
) (
  input  logic signed [vaw_pkg::CW-1:0] x,
  input  logic signed [vaw_pkg::CW-1:0] y,
  output logic [$clog2((2*BOUND+3)*(2*BOUND+3))-1:0] row,
  output logic ok
);
  import vaw_pkg::*;

  localparam int H    = BOUND + 1;
  localparam int SIDE = 2 * BOUND + 3;
  localparam int AW   = $clog2(SIDE * SIDE);
  localparam int EW   = (AW + 1 > CW) ? AW + 1 : CW;
  localparam logic signed [EW-1:0] HS = EW'(H);

  logic signed [EW-1:0] xe;
  logic signed [EW-1:0] ye;
  logic [AW-1:0] xo;
  logic [AW-1:0] yo;

  always_comb begin
    xe  = EW'(x);
    ye  = EW'(y);
    ok  = (xe >= -HS) && (xe <= HS) && (ye >= -HS) && (ye <= HS);
    xo  = AW'(xe + HS);
    yo  = AW'(ye + HS);
    row = AW'(xo * AW'(SIDE)) + yo;
  end

endmodule

// ===== src/voxel_aggregation_walker_step_unit.sv =====
// voxel aggregation walker step unit: 3d aggregation grid, walker moves and commits
// depends on vaw_pkg, vaw_ram, vaw_addr_unit and the assertion macro header
// move: accept, nine z-row reads, a drain state, then the result state; in_tready stays
//   low while in work, so no new word is taken until the result is loaded for output
// commit: a queue read, a row read and an emit per pending point; a held output stalls the emit
// reset starts a clearing pass over (2*BOUND+3)^2 rows (1089 by default), seeding the origin
`include "voxel_aggregation_walker_step_unit_defines.svh"

module voxel_aggregation_walker_step_unit #(
  parameter int BOUND       = 15,
  parameter int MAX_PENDING = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pos_x[4:0] pos_y[9:5] pos_z[14:10] step_x[16:15] step_y[18:17] step_z[20:19]
  // edge_axis[22:21] edge_side[23] edge_first[28:24] edge_second[33:29], zero fill
  input  logic [vaw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command[0]
  input  logic [vaw_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_x[5:0] out_y[11:6] out_z[17:12], zero fill
  output logic [vaw_pkg::OUT_TDATA_W-1:0] out_tdata,
  // kind[2:0]
  output logic [vaw_pkg::KIND_W-1:0]      out_tuser,
  output logic                             out_tlast
);
  import vaw_pkg::*;

  // grid geometry: the grid spans -(BOUND+1)..BOUND+1 on each axis and is
  // stored as one ram row per (x, y) holding all z bits
  localparam int H     = BOUND + 1;
  localparam int SIDE  = 2 * BOUND + 3;
  localparam int ROWS  = SIDE * SIDE;
  localparam int AW    = $clog2(ROWS);
  localparam int ZW    = $clog2(SIDE);
  localparam int EW    = (AW + 1 > CW) ? AW + 1 : CW;
  localparam int PW    = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int CNW   = $clog2(MAX_PENDING + 1);
  localparam logic [AW-1:0]   ORIGIN_ROW  = AW'(H * SIDE + H);
  localparam logic [AW-1:0]   LAST_ROW    = AW'(ROWS - 1);
  localparam logic [SIDE-1:0] ORIGIN_BITS = SIDE'(1) << H;
  localparam logic signed [EW-1:0] HS = EW'(H);
  localparam logic signed [EW-1:0] BS = EW'(BOUND);
  localparam logic [OCW-1:0] FACE_POS = OCW'(BOUND);
  localparam logic [OCW-1:0] FACE_NEG = OCW'(-BOUND);

  vaw_state_t state_r, state_nxt;

  // control registers
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [1:0]     nbx_r, nbx_nxt;
  logic [1:0]     nby_r, nby_nxt;
  logic           rd_vld_r, rd_vld_nxt;
  logic           rd_ctr_r, rd_ctr_nxt;
  logic           stuck_r, stuck_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [CNW-1:0] cm_idx_r, cm_idx_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;

  // payload registers
  logic signed [CW-1:0] px_r, px_nxt;
  logic signed [CW-1:0] py_r, py_nxt;
  logic signed [CW-1:0] pz_r, pz_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic                 side_r, side_nxt;
  logic signed [4:0]    ef_r, ef_nxt;
  logic signed [4:0]    es_r, es_nxt;
  logic signed [CW-1:0] ptx_r, ptx_nxt;
  logic signed [CW-1:0] pty_r, pty_nxt;
  logic signed [CW-1:0] ptz_r, ptz_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [OCW-1:0]       ox_r, ox_nxt;
  logic [OCW-1:0]       oy_r, oy_nxt;
  logic [OCW-1:0]       oz_r, oz_nxt;
  logic                 last_r, last_nxt;

  // ram ports
  logic            g_en, g_we;
  logic [AW-1:0]   g_addr;
  logic [SIDE-1:0] g_wdata, g_rdata;
  logic            p_en, p_we;
  logic [PW-1:0]   p_addr;
  logic [PT_W-1:0] p_wdata, p_rdata;

  // shared address unit
  logic signed [CW-1:0] au_x, au_y;
  logic [AW-1:0]        au_row;
  logic                 au_ok;

  // misc
  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic                 push;
  logic                 cm_last;
  logic                 scan_done;
  logic                 in_cube;
  logic                 outb;
  logic                 hit;
  logic                 solo_kind;
  logic                 cm_kind;
  logic signed [EW-1:0] pxe, pye, pze;
  logic signed [EW-1:0] ze [3];
  logic [2:0]           zok;
  logic [ZW-1:0]        zidx [3];
  logic [ZW-1:0]        ptzi;
  logic [SIDE-1:0]      zbit;
  logic [OCW-1:0]       fa, fb, face;

  vaw_ram #(
    .DW   (SIDE),
    .DEPTH(ROWS),
    .AW   (AW)
  ) u_grid (
    .clk  (clk),
    .en   (g_en),
    .we   (g_we),
    .addr (g_addr),
    .wdata(g_wdata),
    .rdata(g_rdata)
  );

  // pending queue, entries {z, y, x}
  vaw_ram #(
    .DW   (PT_W),
    .DEPTH(MAX_PENDING),
    .AW   (PW)
  ) u_pend (
    .clk  (clk),
    .en   (p_en),
    .we   (p_we),
    .addr (p_addr),
    .wdata(p_wdata),
    .rdata(p_rdata)
  );

  vaw_addr_unit #(
    .BOUND(BOUND)
  ) u_addr (
    .x  (au_x),
    .y  (au_y),
    .row(au_row),
    .ok (au_ok)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {(OUT_TDATA_W - 3 * OCW)'(0), oz_r, oy_r, ox_r};

  assign scan_done = (nbx_r == 2'd2) && (nby_r == 2'd2);
  assign cm_last   = (cm_idx_r == cnt_r - CNW'(1));
  assign push      = stuck_r && (cnt_r < CNW'(MAX_PENDING));
  assign p_wdata   = {pz_r[OCW-1:0], py_r[OCW-1:0], px_r[OCW-1:0]};

  // kinds that always come as a single word, and the kinds of a commit run
  assign solo_kind = kind_r inside {KIND_MOVED, KIND_STUCK, KIND_OUT, KIND_EMPTY};
  assign cm_kind   = kind_nxt inside {KIND_ADDED, KIND_PRESENT};

  // position checks, fixed for the whole move
  always_comb begin
    pxe     = EW'(px_r);
    pye     = EW'(py_r);
    pze     = EW'(pz_r);
    in_cube = (pxe >= -HS) && (pxe <= HS) && (pye >= -HS) && (pye <= HS)
              && (pze >= -HS) && (pze <= HS);
    outb    = (pxe > BS) || (pxe < -BS) || (pye > BS) || (pye < -BS)
              || (pze > BS) || (pze < -BS);
    for (int d = 0; d < 3; d++) begin
      ze[d]   = pze + EW'(d) - EW'(1);
      zok[d]  = (ze[d] >= -HS) && (ze[d] <= HS);
      zidx[d] = ZW'(ze[d] + HS);
    end
  end

  // neighbour hit on the row read last cycle; the walker's own voxel is skipped
  always_comb begin
    hit = 1'b0;
    for (int d = 0; d < 3; d++) begin
      if (zok[d] && !(rd_ctr_r && d == 1) && g_rdata[zidx[d]]) begin
        hit = 1'b1;
      end
    end
    hit = hit && rd_vld_r;
  end

  // address unit input: neighbour row, queued point, or held point
  always_comb begin
    case (state_r)
      ST_CM_GREAD: begin
        au_x = CW'($signed(p_rdata[OCW-1:0]));
        au_y = CW'($signed(p_rdata[2*OCW-1:OCW]));
      end
      ST_CM_EMIT: begin
        au_x = ptx_r;
        au_y = pty_r;
      end
      default: begin
        au_x = px_r + CW'(nbx_r) - CW'(1);
        au_y = py_r + CW'(nby_r) - CW'(1);
      end
    endcase
  end

  // commit bit in the fetched row
  assign ptzi = ZW'(EW'(ptz_r) + HS);
  assign zbit = SIDE'(1) << ptzi;

  // respawn face coordinates
  always_comb begin
    fa   = OCW'(ef_r);
    fb   = OCW'(es_r);
    face = side_r ? FACE_POS : FACE_NEG;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_ROW) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_COMMIT) begin
            state_nxt = (cnt_r == '0) ? ST_CM_EMPTY : ST_CM_PREAD;
          end else begin
            state_nxt = ST_MV_SCAN;
          end
        end
      end
      ST_MV_SCAN: begin
        if (scan_done) state_nxt = ST_MV_LAST;
      end
      ST_MV_LAST:  state_nxt = ST_MV_EMIT;
      ST_MV_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_CM_PREAD: state_nxt = ST_CM_GREAD;
      ST_CM_GREAD: state_nxt = ST_CM_EMIT;
      ST_CM_EMIT: begin
        if (out_free) state_nxt = cm_last ? ST_IDLE : ST_CM_PREAD;
      end
      ST_CM_EMPTY: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ram strobes and output load per state
  always_comb begin
    g_en     = 1'b0;
    g_we     = 1'b0;
    g_addr   = au_row;
    g_wdata  = g_rdata | zbit;
    p_en     = 1'b0;
    p_we     = 1'b0;
    p_addr   = cm_idx_r[PW-1:0];
    out_load = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        g_en    = 1'b1;
        g_we    = 1'b1;
        g_addr  = clr_r;
        g_wdata = (clr_r == ORIGIN_ROW) ? ORIGIN_BITS : '0;
      end
      ST_MV_SCAN: begin
        g_en = 1'b1;
      end
      ST_MV_EMIT: begin
        out_load = out_free;
        p_en     = out_free && push;
        p_we     = out_free && push;
        p_addr   = cnt_r[PW-1:0];
      end
      ST_CM_PREAD: begin
        p_en = 1'b1;
      end
      ST_CM_GREAD: begin
        g_en = 1'b1;
      end
      ST_CM_EMIT: begin
        out_load = out_free;
        g_en     = out_free;
        g_we     = out_free;
      end
      ST_CM_EMPTY: begin
        out_load = out_free;
      end
      default: begin
        g_en = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    clr_nxt    = clr_r;
    nbx_nxt    = nbx_r;
    nby_nxt    = nby_r;
    rd_vld_nxt = (state_r == ST_MV_SCAN) && au_ok && in_cube;
    rd_ctr_nxt = (nbx_r == 2'd1) && (nby_r == 2'd1);
    stuck_nxt  = stuck_r;
    cnt_nxt    = cnt_r;
    cm_idx_nxt = cm_idx_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    pz_nxt     = pz_r;
    axis_nxt   = axis_r;
    side_nxt   = side_r;
    ef_nxt     = ef_r;
    es_nxt     = es_r;
    ptx_nxt    = ptx_r;
    pty_nxt    = pty_r;
    ptz_nxt    = ptz_r;
    kind_nxt   = kind_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oz_nxt     = oz_r;
    last_nxt   = last_r;

    if (state_r == ST_CLEAR) clr_nxt = clr_r + AW'(1);

    if (in_acc) begin
      // stepped position; a step pattern of binary 10 acts as -2
      px_nxt     = CW'($signed(in_tdata[4:0])) + CW'($signed(in_tdata[16:15]));
      py_nxt     = CW'($signed(in_tdata[9:5])) + CW'($signed(in_tdata[18:17]));
      pz_nxt     = CW'($signed(in_tdata[14:10])) + CW'($signed(in_tdata[20:19]));
      axis_nxt   = in_tdata[22:21];
      side_nxt   = in_tdata[23];
      ef_nxt     = $signed(in_tdata[28:24]);
      es_nxt     = $signed(in_tdata[33:29]);
      nbx_nxt    = 2'd0;
      nby_nxt    = 2'd0;
      stuck_nxt  = 1'b0;
      cm_idx_nxt = '0;
    end

    if (state_r == ST_MV_SCAN) begin
      if (nby_r == 2'd2) begin
        nby_nxt = 2'd0;
        nbx_nxt = nbx_r + 2'd1;
      end else begin
        nby_nxt = nby_r + 2'd1;
      end
    end

    if (state_r == ST_MV_SCAN || state_r == ST_MV_LAST) stuck_nxt = stuck_r || hit;

    if (state_r == ST_CM_GREAD) begin
      ptx_nxt = CW'($signed(p_rdata[OCW-1:0]));
      pty_nxt = CW'($signed(p_rdata[2*OCW-1:OCW]));
      ptz_nxt = CW'($signed(p_rdata[3*OCW-1:2*OCW]));
    end

    case (state_r)
      ST_MV_EMIT: begin
        if (out_free && push) cnt_nxt = cnt_r + CNW'(1);
        last_nxt = 1'b1;
        ox_nxt   = px_r[OCW-1:0];
        oy_nxt   = py_r[OCW-1:0];
        oz_nxt   = pz_r[OCW-1:0];
        if (stuck_r) begin
          kind_nxt = KIND_STUCK;
        end else if (outb) begin
          kind_nxt = KIND_OUT;
        end else begin
          kind_nxt = KIND_MOVED;
        end
        if (stuck_r || outb) begin
          case (axis_r)
            AXIS_X: begin
              ox_nxt = face;
              oy_nxt = fa;
              oz_nxt = fb;
            end
            AXIS_Y: begin
              ox_nxt = fa;
              oy_nxt = face;
              oz_nxt = fb;
            end
            default: begin
              ox_nxt = fa;
              oy_nxt = fb;
              oz_nxt = face;
            end
          endcase
        end
      end
      ST_CM_EMIT: begin
        if (out_free) begin
          cm_idx_nxt = cm_idx_r + CNW'(1);
          if (cm_last) cnt_nxt = '0;
        end
        kind_nxt = g_rdata[ptzi] ? KIND_PRESENT : KIND_ADDED;
        ox_nxt   = ptx_r[OCW-1:0];
        oy_nxt   = pty_r[OCW-1:0];
        oz_nxt   = ptz_r[OCW-1:0];
        last_nxt = cm_last;
      end
      ST_CM_EMPTY: begin
        kind_nxt = KIND_EMPTY;
        ox_nxt   = '0;
        oy_nxt   = '0;
        oz_nxt   = '0;
        last_nxt = 1'b1;
      end
      default: begin
        kind_nxt = kind_r;
      end
    endcase

    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      nbx_r        <= '0;
      nby_r        <= '0;
      rd_vld_r     <= 1'b0;
      rd_ctr_r     <= 1'b0;
      stuck_r      <= 1'b0;
      cnt_r        <= '0;
      cm_idx_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      nbx_r        <= nbx_nxt;
      nby_r        <= nby_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_ctr_r     <= rd_ctr_nxt;
      stuck_r      <= stuck_nxt;
      cnt_r        <= cnt_nxt;
      cm_idx_r     <= cm_idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    pz_r   <= pz_nxt;
    axis_r <= axis_nxt;
    side_r <= side_nxt;
    ef_r   <= ef_nxt;
    es_r   <= es_nxt;
    ptx_r  <= ptx_nxt;
    pty_r  <= pty_nxt;
    ptz_r  <= ptz_nxt;
    if (out_load) begin
      kind_r <= kind_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
      last_r <= last_nxt;
    end
  end

  `VAW_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r <= CNW'(MAX_PENDING), "pending count past capacity")
  `VAW_ASSERT_IMP(a_single_last, out_tvalid_r && solo_kind, last_r, "single word without last")
  `VAW_ASSERT_NXT(a_commit_drain, out_load && last_nxt && cm_kind, cnt_r == '0, "queue not emptied")
  `VAW_ASSERT_IMP(a_clear_quiet, state_r == ST_CLEAR, !out_tvalid_r && !p_en, "busy while clearing")

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the voxel aggregation walker step unit
// depends on vaw_pkg and voxel_aggregation_walker_step_unit; a directed table, then random
// walker growth, queue flooding and noise, all checked against a local aggregate model
`timescale 1ns / 100ps

module testbench;
  import vaw_pkg::*;

  localparam int BOUND       = 15;
  localparam int MAX_PENDING = 32;
  localparam int HALF        = BOUND + 1;
  localparam int GRID_SIDE   = 2 * BOUND + 3;
  localparam int POS_MIN     = -16;
  localparam int POS_MAX     = 15;
  localparam int DATA_W      = 34;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 40;
  localparam int LIMIT       = 2000000;

  // z face, and the spare axis code that the block treats as z
  localparam logic [1:0] AXIS_Z     = 2'd2;
  localparam logic [1:0] AXIS_SPARE = 2'd3;

  // one input word, packed so that the low DATA_W bits are the tdata layout
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [4:0]       edge_second;
    logic [4:0]       edge_first;
    logic             edge_side;
    logic [1:0]       edge_axis;
    logic [1:0]       step_z;
    logic [1:0]       step_y;
    logic [1:0]       step_x;
    logic [4:0]       pos_z;
    logic [4:0]       pos_y;
    logic [4:0]       pos_x;
  } walker_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [5:0]        x;
    logic [5:0]        y;
    logic [5:0]        z;
    logic              last;
  } voxel_report_t;

  typedef struct packed {
    walker_word_t  word;
    logic          pinned;
    voxel_report_t report;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  // local copy of the aggregate: grid as of the last commit plus the stuck queue
  bit            aggregate [0:GRID_SIDE-1][0:GRID_SIDE-1][0:GRID_SIDE-1];
  int            queued_x [0:MAX_PENDING-1];
  int            queued_y [0:MAX_PENDING-1];
  int            queued_z [0:MAX_PENDING-1];
  int            queued_count = 0;
  voxel_report_t walker_reports[$];

  directed_row_t directed_rows [0:23];
  int            directed_len = 0;

  int failures      = 0;
  int words_sent    = 0;
  int commits_sent  = 0;
  int results_seen  = 0;
  int dropped_points = 0;
  int kinds_seen [0:7];
  int hold_asks     = 0;
  bit steady        = 1'b0;
  int cycle_count   = 0;

  voxel_aggregation_walker_step_unit #(
    .BOUND      (BOUND),
    .MAX_PENDING(MAX_PENDING)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit on_grid(int c);
    return c >= -HALF && c <= HALF;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic voxel_report_t make_report(logic [KIND_W-1:0] kind, int x, int y, int z,
                                                logic last);
    voxel_report_t r;
    r.kind = kind;
    r.x    = x[5:0];
    r.y    = y[5:0];
    r.z    = z[5:0];
    r.last = last;
    return r;
  endfunction

  // applies one word to the local aggregate and queues the result words it should cause
  function automatic void advance_aggregate(walker_word_t w);
    logic [KIND_W-1:0] kind;
    int px, py, pz, fa, fb, face;
    bit in_cube, stuck, beyond;
    if (w.command == CMD_COMMIT) begin
      if (queued_count == 0) begin
        walker_reports.push_back(make_report(KIND_EMPTY, 0, 0, 0, 1'b1));
        return;
      end
      // queue order; a later copy of the same point finds it already set
      for (int i = 0; i < queued_count; i++) begin
        px = queued_x[i];
        py = queued_y[i];
        pz = queued_z[i];
        kind = aggregate[px + HALF][py + HALF][pz + HALF] ? KIND_PRESENT : KIND_ADDED;
        aggregate[px + HALF][py + HALF][pz + HALF] = 1'b1;
        walker_reports.push_back(make_report(kind, px, py, pz, i == queued_count - 1));
      end
      queued_count = 0;
      return;
    end

    // a step pattern of binary 10 counts as -2
    px = $signed(w.pos_x) + $signed(w.step_x);
    py = $signed(w.pos_y) + $signed(w.step_y);
    pz = $signed(w.pos_z) + $signed(w.step_z);
    in_cube = on_grid(px) && on_grid(py) && on_grid(pz);
    stuck = 1'b0;
    if (in_cube)
      for (int dx = -1; dx <= 1; dx++)
        for (int dy = -1; dy <= 1; dy++)
          for (int dz = -1; dz <= 1; dz++)
            if ((dx != 0 || dy != 0 || dz != 0) && on_grid(px + dx) && on_grid(py + dy)
                && on_grid(pz + dz) && aggregate[px + dx + HALF][py + dy + HALF][pz + dz + HALF])
              stuck = 1'b1;
    beyond = px > BOUND || px < -BOUND || py > BOUND || py < -BOUND
             || pz > BOUND || pz < -BOUND;

    kind = KIND_MOVED;
    if (stuck) begin
      // a full queue drops the point but the walker still respawns
      if (queued_count < MAX_PENDING) begin
        queued_x[queued_count] = px;
        queued_y[queued_count] = py;
        queued_z[queued_count] = pz;
        queued_count++;
      end else begin
        dropped_points++;
      end
      kind = KIND_STUCK;
    end else if (beyond) begin
      kind = KIND_OUT;
    end

    if (kind != KIND_MOVED) begin
      fa   = $signed(w.edge_first);
      fb   = $signed(w.edge_second);
      face = w.edge_side ? BOUND : -BOUND;
      if (w.edge_axis == AXIS_X) begin
        px = face; py = fa; pz = fb;
      end else if (w.edge_axis == AXIS_Y) begin
        px = fa; py = face; pz = fb;
      end else begin
        px = fa; py = fb; pz = face;
      end
    end
    walker_reports.push_back(make_report(kind, px, py, pz, 1'b1));
  endfunction

  function automatic walker_word_t compose_word(logic [CMD_W-1:0] cmd, int px, int py, int pz,
                                                int sx, int sy, int sz, int axis, int side,
                                                int first, int second);
    walker_word_t w;
    w.command     = cmd;
    w.pos_x       = px[4:0];
    w.pos_y       = py[4:0];
    w.pos_z       = pz[4:0];
    w.step_x      = sx[1:0];
    w.step_y      = sy[1:0];
    w.step_z      = sz[1:0];
    w.edge_axis   = axis[1:0];
    w.edge_side   = side[0];
    w.edge_first  = first[4:0];
    w.edge_second = second[4:0];
    return w;
  endfunction

  // a move that lands on the target through a random step, respawn fields random
  function automatic walker_word_t aim_at(int tx, int ty, int tz);
    int sx, sy, sz;
    do sx = int'($urandom_range(0, 3)) - 2; while (tx - sx < POS_MIN || tx - sx > POS_MAX);
    do sy = int'($urandom_range(0, 3)) - 2; while (ty - sy < POS_MIN || ty - sy > POS_MAX);
    do sz = int'($urandom_range(0, 3)) - 2; while (tz - sz < POS_MIN || tz - sz > POS_MAX);
    return compose_word(CMD_MOVE, tx - sx, ty - sy, tz - sz, sx, sy, sz,
                        $urandom_range(0, 3), $urandom_range(0, 1),
                        $urandom_range(0, 31), $urandom_range(0, 31));
  endfunction

  function automatic walker_word_t noise_word();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(walker_word_t)-1:0];
  endfunction

  function automatic walker_word_t commit_word();
    walker_word_t w;
    w = noise_word();
    w.command = CMD_COMMIT;
    return w;
  endfunction

  // sender gap after an accepted word: mostly none, some short, a few long
  function automatic int idle_gap();
    int roll;
    if (steady)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic add_row(logic [CMD_W-1:0] cmd, int px, int py, int pz, int sx, int sy, int sz,
                         int axis, int side, int first, int second);
    directed_rows[directed_len].word   = compose_word(cmd, px, py, pz, sx, sy, sz, axis, side,
                                                      first, second);
    directed_rows[directed_len].pinned = 1'b0;
    directed_rows[directed_len].report = '0;
    directed_len++;
  endtask

  // single-word results that can be read straight off the row
  task automatic pin_report(logic [KIND_W-1:0] kind, int x, int y, int z);
    directed_rows[directed_len - 1].pinned = 1'b1;
    directed_rows[directed_len - 1].report = make_report(kind, x, y, z, 1'b1);
  endtask

  // offers one word from the falling edge, predicts at the accepting rising edge
  task automatic send_word(walker_word_t w, logic pinned, voxel_report_t pinned_report);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= w.command;
    in_tdata  <= {{(IN_TDATA_W - DATA_W){1'b0}}, w[DATA_W-1:0]};
    do @(posedge clk); while (!in_tready);
    advance_aggregate(w);
    if (pinned) begin
      void'(walker_reports.pop_back());
      walker_reports.push_back(pinned_report);
    end
    words_sent++;
    if (w.command == CMD_COMMIT)
      commits_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // receiver: ready stretches, short and long stalls, and the requested long hold-off
  initial begin : receiver
    int roll;
    int span;
    int hold_served;
    hold_served = 0;
    out_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_served) begin
        hold_served++;
        out_tready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++)
          @(negedge clk);
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          out_tready <= 1'b1;
          span = $urandom_range(1, 20);
        end else begin
          out_tready <= 1'b0;
          if (roll < 90)
            span = $urandom_range(1, 3);
          else if (roll < 97)
            span = $urandom_range(4, 12);
          else
            span = $urandom_range(20, 60);
        end
        repeat (span - 1) @(negedge clk);
      end
    end
  end

  // every accepted result word against the oldest prediction
  always @(posedge clk) begin : result_check
    voxel_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      kinds_seen[out_tuser]++;
      if (walker_reports.size() == 0) begin
        $error("result word with nothing predicted: kind %0d", out_tuser);
        failures++;
      end else begin
        want = walker_reports.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          failures++;
        end
        if (out_tdata[5:0] !== want.x) begin
          $error("out_x: expected %0d, got %0d", $signed(want.x), $signed(out_tdata[5:0]));
          failures++;
        end
        if (out_tdata[11:6] !== want.y) begin
          $error("out_y: expected %0d, got %0d", $signed(want.y), $signed(out_tdata[11:6]));
          failures++;
        end
        if (out_tdata[17:12] !== want.z) begin
          $error("out_z: expected %0d, got %0d", $signed(want.z), $signed(out_tdata[17:12]));
          failures++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          failures++;
        end
      end
    end
  end

  // run limit, covers the clearing pass after reset as well
  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d result words outstanding", cycle_count,
             walker_reports.size());
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int mark_x[$];
    int mark_y[$];
    int mark_z[$];
    int tx, ty, tz, dx, dy, dz, pick, roll, axis, sign;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_MOVE;
    for (int k = 0; k < 8; k++)
      kinds_seen[k] = 0;
    // the seed
    aggregate[HALF][HALF][HALF] = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table; respawn fields are axis, side, first, second
    add_row(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);           // nothing pending
    pin_report(KIND_EMPTY, 0, 0, 0);
    add_row(CMD_MOVE, 0, 0, 3, 0, 0, -1, AXIS_X, 0, 0, 0);        // two away, free
    pin_report(KIND_MOVED, 0, 0, 2);
    add_row(CMD_MOVE, 2, 0, 0, -2, 0, 0, AXIS_Y, 1, 5, 5);        // lands on the seed itself
    pin_report(KIND_MOVED, 0, 0, 0);
    add_row(CMD_MOVE, 0, 0, 2, 0, 0, -1, AXIS_X, 1, 3, -4);       // touches the seed
    pin_report(KIND_STUCK, BOUND, 3, -4);
    add_row(CMD_MOVE, 3, 1, 1, -2, 0, 0, AXIS_Y, 0, -16, 15);     // diagonal touch, -2 step
    pin_report(KIND_STUCK, -16, -BOUND, 15);
    add_row(CMD_MOVE, 15, 15, 15, 1, 1, 1, AXIS_Z, 1, -15, 15);   // grid corner, out of bounds
    pin_report(KIND_OUT, -15, 15, BOUND);
    add_row(CMD_MOVE, -16, -16, -16, -2, -2, -2, AXIS_SPARE, 0, 15, -16); // off the grid
    pin_report(KIND_OUT, 15, -16, -BOUND);
    add_row(CMD_MOVE, 15, 0, 0, 0, 0, 0, AXIS_Z, 1, 1, 1);        // on the bound, still free
    pin_report(KIND_MOVED, 15, 0, 0);
    add_row(CMD_MOVE, -16, 0, 0, 0, 0, 0, AXIS_Y, 1, 7, -7);      // grid edge, out of bounds
    pin_report(KIND_OUT, 7, BOUND, -7);
    add_row(CMD_MOVE, 0, -1, 0, 0, 0, 0, AXIS_Z, 0, 0, 0);
    pin_report(KIND_STUCK, 0, 0, -BOUND);
    add_row(CMD_MOVE, 0, 0, 1, 0, 0, 0, AXIS_X, 0, -1, 1);        // same point queued twice
    pin_report(KIND_STUCK, -BOUND, -1, 1);
    add_row(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);            // three added, one present
    add_row(CMD_MOVE, 0, 0, 2, 0, 0, 0, AXIS_Y, 1, 2, 2);         // touches the new point
    add_row(CMD_MOVE, 1, 1, 1, 0, 0, 0, AXIS_SPARE, 1, -3, 3);    // stuck on an occupied voxel
    add_row(CMD_MOVE, -15, -15, -15, -1, -1, -1, AXIS_X, 0, 9, -9);
    add_row(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    pin_report(KIND_EMPTY, 0, 0, 0);
    add_row(CMD_MOVE, -16, 15, -16, 1, -2, -1, AXIS_SPARE, 1, 31, 16);
    for (int n = 0; n < directed_len; n++)
      send_word(directed_rows[n].word, directed_rows[n].pinned, directed_rows[n].report);

    mark_x.push_back(0);
    mark_y.push_back(0);
    mark_z.push_back(0);

    // grow a jittered spike out to the grid face, at least one committed voxel per round
    axis = $urandom_range(0, 2);
    sign = $urandom_range(0, 1) ? 1 : -1;
    tx = 0; ty = 0; tz = 0;
    for (int r = 1; r <= HALF; r++) begin
      tx = (axis == 0) ? sign * r : clamp(tx + int'($urandom_range(0, 2)) - 1, -12, 12);
      ty = (axis == 1) ? sign * r : clamp(ty + int'($urandom_range(0, 2)) - 1, -12, 12);
      tz = (axis == 2) ? sign * r : clamp(tz + int'($urandom_range(0, 2)) - 1, -12, 12);
      send_word(aim_at(tx, ty, tz), 1'b0, '0);
      if ($urandom_range(0, 3) == 0)
        send_word(aim_at(clamp(tx + int'($urandom_range(0, 4)) - 2, -HALF, HALF),
                         clamp(ty + int'($urandom_range(0, 4)) - 2, -HALF, HALF),
                         clamp(tz + int'($urandom_range(0, 4)) - 2, -HALF, HALF)), 1'b0, '0);
      send_word(commit_word(), 1'b0, '0);
      mark_x.push_back(tx);
      mark_y.push_back(ty);
      mark_z.push_back(tz);
    end

    // flood the queue around the seed past its capacity, receiver held off meanwhile
    hold_asks++;
    for (int n = 0; n < MAX_PENDING + 4; n++) begin
      do begin
        dx = int'($urandom_range(0, 2)) - 1;
        dy = int'($urandom_range(0, 2)) - 1;
        dz = int'($urandom_range(0, 2)) - 1;
      end while (dx == 0 && dy == 0 && dz == 0);
      send_word(aim_at(dx, dy, dz), 1'b0, '0);
    end
    send_word(commit_word(), 1'b0, '0);

    // mixed walk near the aggregate, with commits and raw noise; first stretch without idling
    for (int n = 0; n < 30; n++) begin
      steady = (n < 10);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_word(commit_word(), 1'b0, '0);
      end else if (roll < 22) begin
        send_word(noise_word(), 1'b0, '0);
      end else begin
        pick = $urandom_range(0, mark_x.size() - 1);
        send_word(aim_at(clamp(mark_x[pick] + int'($urandom_range(0, 4)) - 2, -HALF, HALF),
                         clamp(mark_y[pick] + int'($urandom_range(0, 4)) - 2, -HALF, HALF),
                         clamp(mark_z[pick] + int'($urandom_range(0, 4)) - 2, -HALF, HALF)),
                  1'b0, '0);
      end
    end
    steady = 1'b0;
    send_word(commit_word(), 1'b0, '0);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (walker_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d words (%0d commits), checked %0d result words, %0d points dropped full",
             words_sent, commits_sent, results_seen, dropped_points);
    $display("kinds seen: moved %0d stuck %0d out %0d added %0d present %0d empty %0d",
             kinds_seen[KIND_MOVED], kinds_seen[KIND_STUCK], kinds_seen[KIND_OUT],
             kinds_seen[KIND_ADDED], kinds_seen[KIND_PRESENT], kinds_seen[KIND_EMPTY]);
    if (failures == 0 && walker_reports.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
